// ----- design/lik_pkg.sv -----
// Package for the leg inverse kinematics core: field widths, angle constants,
// CORDIC arc table and small helper functions. No dependencies.
`default_nettype none

package lik_pkg;

    localparam int NUM_LEGS_DEF  = 6;
    localparam int CORDIC_STEPS  = 23;

    localparam int COORD_W = 16;
    localparam int LEN_W   = 13;
    localparam int LIM_W   = 7;
    localparam int PULSE_W = 12;
    localparam int TIME_W  = 16;
    localparam int ARC_W   = 25;  // first-quadrant angle and atan2 result, Q.16 degrees
    localparam int ANG_W   = 27;  // joint angle arithmetic
    localparam int CORD_W  = 45;  // CORDIC vector registers
    localparam int ATIN_W  = 35;  // atan2 operand width
    localparam int NUM_W   = 35;  // acos numerator
    localparam int DEN_W   = 31;  // acos denominator
    localparam int ROOT_W  = 64;  // square root working width

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 56;

    localparam logic signed [ARC_W-1:0] DEG45  = 25'sd2949120;
    localparam logic signed [ARC_W-1:0] DEG90  = 25'sd5898240;
    localparam logic signed [ARC_W-1:0] DEG180 = 25'sd11796480;

    localparam logic [PULSE_W-1:0] PULSE_MIN = 12'd900;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd2100;
    localparam logic [PULSE_W-1:0] CENTER_RESET = 12'd1500;

    typedef enum logic [1:0] {
        OP_ABS   = 2'd0,
        OP_REL   = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_COXA_LEN  = 3'd0,
        REG_FEMUR_LEN = 3'd1,
        REG_TIBIA_LEN = 3'd2,
        REG_CORNER    = 3'd3,
        REG_MID_BACK  = 3'd4,
        REG_MID_FWD   = 3'd5,
        REG_JOINT     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_FRONT = 2'd0,
        KIND_MID   = 2'd1,
        KIND_REAR  = 2'd2
    } leg_kind_t;

    function automatic logic signed [ARC_W-1:0] arc_at(input logic [4:0] i);
        logic signed [ARC_W-1:0] a;
        case (i)
            5'd0:  a = 25'sd2949120;
            5'd1:  a = 25'sd1740967;
            5'd2:  a = 25'sd919879;
            5'd3:  a = 25'sd466945;
            5'd4:  a = 25'sd234379;
            5'd5:  a = 25'sd117304;
            5'd6:  a = 25'sd58666;
            5'd7:  a = 25'sd29335;
            5'd8:  a = 25'sd14668;
            5'd9:  a = 25'sd7334;
            5'd10: a = 25'sd3667;
            5'd11: a = 25'sd1833;
            5'd12: a = 25'sd917;
            5'd13: a = 25'sd458;
            5'd14: a = 25'sd229;
            5'd15: a = 25'sd115;
            5'd16: a = 25'sd57;
            5'd17: a = 25'sd29;
            5'd18: a = 25'sd14;
            5'd19: a = 25'sd7;
            5'd20: a = 25'sd4;
            5'd21: a = 25'sd2;
            5'd22: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Wrap the leg index into the number of legs.
    function automatic logic [2:0] leg_wrap(input logic [2:0] idx, input int n);
        int v;
        v = int'(idx);
        for (int k = 0; k < 8; k++) begin
            if (v >= n) v = v - n;
        end
        return 3'(v);
    endfunction

    function automatic leg_kind_t leg_kind(input logic [2:0] leg);
        leg_kind_t k;
        case (leg)
            3'd0, 3'd3, 3'd6: k = KIND_FRONT;
            3'd1, 3'd4, 3'd7: k = KIND_MID;
            default:          k = KIND_REAR;
        endcase
        return k;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 17'sd32767)       r = 16'sh7FFF;
        else if (v < -17'sd32768) r = 16'sh8000;
        else                      r = v[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] c);
        logic [PULSE_W-1:0] r;
        if (c < PULSE_MIN)      r = PULSE_MIN;
        else if (c > PULSE_MAX) r = PULSE_MAX;
        else                    r = c;
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [ANG_W-1:0] v,
                                                          input logic signed [ANG_W-1:0] lo,
                                                          input logic signed [ANG_W-1:0] hi);
        logic signed [ANG_W-1:0] r;
        if (v < lo)      r = lo;
        else if (v > hi) r = hi;
        else             r = v;
        return r;
    endfunction

    // Pulse = floor(centre + s*angle*600/90), clamped. Works on floor(num / 2^16),
    // then divides by 3 with a reciprocal that is exact below 6300.
    function automatic logic [PULSE_W-1:0] to_pulse(input logic [PULSE_W-1:0] centre,
                                                    input logic signed [ANG_W-1:0] angle,
                                                    input logic neg);
        logic signed [32:0] sa;
        logic signed [32:0] prod;
        logic signed [16:0] w;
        logic [13:0]        c3;
        logic signed [17:0] t;
        logic [27:0]        q;
        logic [PULSE_W-1:0] r;
        sa   = neg ? -33'(angle) : 33'(angle);
        prod = sa * 33'sd20;
        w    = prod[32:16];
        c3   = {1'b0, centre, 1'b0} + {2'b0, centre};
        t    = $signed({4'b0, c3}) + $signed({w[16], w});
        q    = {15'b0, t[12:0]} * 28'd21846;
        if (t < 18'sd2700)       r = PULSE_MIN;
        else if (t >= 18'sd6300) r = PULSE_MAX;
        else                     r = q[27:16];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/leg_inverse_kinematics_core.sv -----
// Top level of the leg inverse kinematics core: sequencer, shared multiplier,
// shared square root and CORDIC atan2 units. Depends on lik_pkg.
`default_nettype none

// Channel  | Direction | Handshake          | Content
// s_       | in        | s_tvalid/s_tready  | request: opcode in tuser, leg, target, centres
// m_       | out       | m_tvalid/m_tready  | result: leg, three pulses, time; flag in tuser
// cfg_     | in        | cfg_wr_en          | register write, no wait
//
// A write request goes straight to done; an unused opcode starts no work.
// A solve runs up to four 32-step square roots and up to four atan2 runs
// (up to 14 normalize steps and 23 CORDIC steps each) on the shared units.
// Reset clears the foot positions and loads all centres with 1500 at once.
// s_tready is high only in idle; a finished result waits in the output register
// while the next request is taken, and the sequencer holds at its end until free.

module leg_inverse_kinematics_core #(
    parameter int NUM_LEGS = lik_pkg::NUM_LEGS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // leg_index, x_pos, y_pos, z_pos, coxa_center, femur_center, tibia_center,
    // move_time, zero pad
    input  wire logic [lik_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // leg_echo, coxa_pulse, femur_pulse, tibia_pulse, time_echo, zero pad
    output logic [lik_pkg::OUT_DATA_W-1:0]         m_tdata,
    // unreachable
    output logic                                   m_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [lik_pkg::LEN_W-1:0]         cfg_data
);

    localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;

    typedef enum logic [26:0] {
        ST_IDLE  = 27'h0000001,
        ST_SQX   = 27'h0000002,
        ST_SQY   = 27'h0000004,
        ST_R1    = 27'h0000008,
        ST_D     = 27'h0000010,
        ST_SQD   = 27'h0000020,
        ST_SQZ   = 27'h0000040,
        ST_R2    = 27'h0000080,
        ST_LF2   = 27'h0000100,
        ST_LT2   = 27'h0000200,
        ST_LFR   = 27'h0000400,
        ST_LTLF  = 27'h0000800,
        ST_NUMS  = 27'h0001000,
        ST_COX   = 27'h0002000,
        ST_COXD  = 27'h0004000,
        ST_F1D   = 27'h0008000,
        ST_AC    = 27'h0010000,
        ST_ACM   = 27'h0020000,
        ST_ACQ   = 27'h0040000,
        ST_ACA   = 27'h0080000,
        ST_ACD   = 27'h0100000,
        ST_PUL   = 27'h0200000,
        ST_DONE  = 27'h0400000,
        ST_SQRT  = 27'h0800000,
        ST_ANORM = 27'h1000000,
        ST_AROT  = 27'h2000000,
        ST_AFIN  = 27'h4000000
    } state_t;

    state_t state_reg, state_next, sq_ret_reg, at_ret_reg;

    // configuration
    logic [lik_pkg::LEN_W-1:0] lc_reg, lf_reg, lt_reg;
    logic [lik_pkg::LIM_W-1:0] corner_reg, back_reg, fwd_reg, jlim_reg;

    // per-leg state
    logic signed [lik_pkg::COORD_W-1:0] foot_x_reg [NUM_LEGS];
    logic signed [lik_pkg::COORD_W-1:0] foot_y_reg [NUM_LEGS];
    logic signed [lik_pkg::COORD_W-1:0] foot_z_reg [NUM_LEGS];
    logic [lik_pkg::PULSE_W-1:0]        jc_c_reg [NUM_LEGS];
    logic [lik_pkg::PULSE_W-1:0]        jc_f_reg [NUM_LEGS];
    logic [lik_pkg::PULSE_W-1:0]        jc_t_reg [NUM_LEGS];

    // request fields
    lik_pkg::opcode_t                   in_op;
    logic [2:0]                         in_leg;
    logic [LEG_W-1:0]                   in_idx;
    logic signed [lik_pkg::COORD_W-1:0] in_x, in_y, in_z;
    logic [lik_pkg::PULSE_W-1:0]        in_cc, in_fc, in_tc;
    logic [lik_pkg::TIME_W-1:0]         in_time;
    logic signed [lik_pkg::COORD_W-1:0] new_x, new_y, new_z;
    logic                               accept;

    // working registers
    logic [2:0]                         leg_reg;
    logic [LEG_W-1:0]                   idx_reg;
    logic [lik_pkg::TIME_W-1:0]         time_reg;
    logic signed [lik_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic signed [16:0]                 d_reg, zo_reg;
    logic [32:0]                        sum_reg, r2_reg;
    logic [15:0]                        r_reg;
    logic [25:0]                        lf2_reg, lt2_reg;
    logic [lik_pkg::DEN_W-1:0]          den1_reg, den2_reg;
    logic signed [lik_pkg::NUM_W-1:0]   num1_reg, num2_reg, nc_reg;
    logic [lik_pkg::DEN_W-1:0]          p_reg;
    logic [31:0]                        q_reg;
    logic                               acs_reg, unr_reg;
    logic signed [lik_pkg::ANG_W-1:0]   cox_reg, fem_reg, tib_reg;
    logic signed [lik_pkg::ARC_W-1:0]   f1_reg;
    logic [1:0]                         pcnt_reg;
    logic [lik_pkg::PULSE_W-1:0]        pc_reg, pf_reg, pt_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_reg;

    // shared square root
    logic                        sq_go;
    logic [lik_pkg::ROOT_W-1:0]  sq_in;
    logic [lik_pkg::ROOT_W-1:0]  sq_v_reg, sq_r_reg, sq_b_reg, sq_rb;
    logic [4:0]                  sq_cnt_reg;

    // shared atan2
    logic                              at_go;
    logic signed [lik_pkg::ATIN_W-1:0] at_y_in, at_x_in;
    logic [lik_pkg::ATIN_W-1:0]        at_ay, at_ax;
    logic signed [lik_pkg::CORD_W-1:0] cx_reg, cy_reg, at_dx, at_dy;
    logic [lik_pkg::CORD_W-1:0]        at_or;
    logic signed [lik_pkg::ARC_W-1:0]  z_reg_a, at_res_reg, at_clip, at_half;
    logic [4:0]                        at_i_reg;
    logic                              at_xneg_reg, at_yneg_reg;

    // acos front end
    logic signed [lik_pkg::NUM_W-1:0] ac_num, ac_denw, ac_clip;
    logic [lik_pkg::DEN_W-1:0]        ac_den, ac_an;
    logic                             ac_sat;

    // angle post-processing
    logic signed [lik_pkg::ANG_W-1:0] jl_ang, cox_raw, cox_lo, cox_hi, fem_raw, tib_raw;
    lik_pkg::leg_kind_t               kind;

    // pulse unit
    logic [lik_pkg::PULSE_W-1:0]      pu_center, pu_out;
    logic signed [lik_pkg::ANG_W-1:0] pu_angle;
    logic                             pu_neg;

    logic                             out_load;
    logic                             m_valid_reg;
    logic [2:0]                       m_leg_reg;
    logic [lik_pkg::PULSE_W-1:0]      m_pc_reg, m_pf_reg, m_pt_reg;
    logic [lik_pkg::TIME_W-1:0]       m_time_reg;
    logic                             m_unr_reg;

    // ---------------- request decode ----------------
    assign in_op   = lik_pkg::opcode_t'(s_tuser);
    assign in_leg  = lik_pkg::leg_wrap(s_tdata[2:0], NUM_LEGS);
    assign in_idx  = LEG_W'(in_leg);
    assign in_x    = s_tdata[18:3];
    assign in_y    = s_tdata[34:19];
    assign in_z    = s_tdata[50:35];
    assign in_cc   = s_tdata[62:51];
    assign in_fc   = s_tdata[74:63];
    assign in_tc   = s_tdata[86:75];
    assign in_time = s_tdata[102:87];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (in_op == lik_pkg::OP_REL) begin
            new_x = lik_pkg::sat16(17'(in_x) + 17'(foot_x_reg[in_idx]));
            new_y = lik_pkg::sat16(17'(in_y) + 17'(foot_y_reg[in_idx]));
            new_z = lik_pkg::sat16(17'(in_z) + 17'(foot_z_reg[in_idx]));
        end else begin
            new_x = in_x;
            new_y = in_y;
            new_z = in_z;
        end
    end

    // ---------------- shared multiplier operands ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = 32'(x_reg[15] ? -17'(x_reg) : 17'(x_reg));
                mul_b = mul_a;
            end
            ST_SQY: begin
                mul_a = 32'(y_reg[15] ? -17'(y_reg) : 17'(y_reg));
                mul_b = mul_a;
            end
            ST_SQD: begin
                mul_a = 32'(d_reg[16] ? -d_reg : d_reg);
                mul_b = mul_a;
            end
            ST_SQZ: begin
                mul_a = 32'(zo_reg[16] ? -zo_reg : zo_reg);
                mul_b = mul_a;
            end
            ST_LF2: begin
                mul_a = 32'(lf_reg);
                mul_b = 32'(lf_reg);
            end
            ST_LT2: begin
                mul_a = 32'(lt_reg);
                mul_b = 32'(lt_reg);
            end
            ST_LFR: begin
                mul_a = 32'(lf_reg);
                mul_b = 32'(r_reg);
            end
            ST_LTLF: begin
                mul_a = 32'(lt_reg);
                mul_b = 32'(lf_reg);
            end
            ST_ACM: begin
                mul_a = 32'(p_reg);
                mul_b = q_reg;
            end
            default: ;
        endcase
    end

    // ---------------- unit starts ----------------
    always_comb begin
        sq_go = 1'b0;
        sq_in = '0;
        case (state_reg)
            ST_R1: begin
                sq_go = 1'b1;
                sq_in = 64'(sum_reg) + mul_reg;
            end
            ST_R2: begin
                sq_go = 1'b1;
                sq_in = 64'(sum_reg) + mul_reg;
            end
            ST_ACQ: begin
                sq_go = 1'b1;
                sq_in = mul_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        at_go   = 1'b0;
        at_y_in = '0;
        at_x_in = '0;
        case (state_reg)
            ST_COX: begin
                at_go   = 1'b1;
                at_y_in = 35'(y_reg);
                at_x_in = 35'(x_reg);
            end
            ST_COXD: begin
                at_go   = 1'b1;
                at_y_in = 35'(zo_reg[16] ? -d_reg : d_reg);
                at_x_in = 35'(zo_reg[16] ? -zo_reg : zo_reg);
            end
            ST_ACA: begin
                at_go   = 1'b1;
                at_y_in = $signed({1'b0, sq_r_reg[33:0]});
                at_x_in = nc_reg;
            end
            default: ;
        endcase
    end

    assign at_ay = at_y_in[lik_pkg::ATIN_W-1] ? 35'(-at_y_in) : 35'(at_y_in);
    assign at_ax = at_x_in[lik_pkg::ATIN_W-1] ? 35'(-at_x_in) : 35'(at_x_in);

    // ---------------- unit datapath ----------------
    assign sq_rb = sq_r_reg + sq_b_reg;

    assign at_or = cx_reg | cy_reg;
    assign at_dx = cy_reg >>> at_i_reg;
    assign at_dy = cx_reg >>> at_i_reg;

    always_comb begin
        if (z_reg_a < 0)                 at_clip = '0;
        else if (z_reg_a > lik_pkg::DEG90) at_clip = lik_pkg::DEG90;
        else                             at_clip = z_reg_a;
        at_half = at_xneg_reg ? (lik_pkg::DEG180 - at_clip) : at_clip;
    end

    // acos: clamp the numerator into the denominator's range
    always_comb begin
        ac_num  = acs_reg ? num2_reg : num1_reg;
        ac_den  = acs_reg ? den2_reg : den1_reg;
        ac_denw = $signed({4'b0, ac_den});
        ac_sat  = 1'b0;
        ac_clip = ac_num;
        if (ac_num > ac_denw) begin
            ac_clip = ac_denw;
            ac_sat  = 1'b1;
        end else if (ac_num < -ac_denw) begin
            ac_clip = -ac_denw;
            ac_sat  = 1'b1;
        end
        ac_an = ac_clip[lik_pkg::NUM_W-1] ? 31'(-ac_clip) : 31'(ac_clip);
    end

    // ---------------- angle limits ----------------
    assign kind   = lik_pkg::leg_kind(leg_reg);
    assign jl_ang = $signed({4'b0, jlim_reg, 16'b0});

    always_comb begin
        cox_raw = 27'(at_res_reg);
        cox_lo  = -$signed({4'b0, corner_reg, 16'b0});
        cox_hi  = $signed({4'b0, corner_reg, 16'b0});
        unique case (kind)
            lik_pkg::KIND_FRONT: cox_raw = 27'(at_res_reg) - 27'(lik_pkg::DEG45);
            lik_pkg::KIND_REAR:  cox_raw = 27'(at_res_reg) + 27'(lik_pkg::DEG45);
            default: begin
                cox_lo = -$signed({4'b0, back_reg, 16'b0});
                cox_hi = $signed({4'b0, fwd_reg, 16'b0});
            end
        endcase
        fem_raw = 27'(lik_pkg::DEG90) - (27'(f1_reg) + 27'(at_res_reg));
        tib_raw = 27'(lik_pkg::DEG90) - 27'(at_res_reg);
    end

    // ---------------- pulse unit ----------------
    always_comb begin
        case (pcnt_reg)
            2'd0: begin
                pu_center = jc_c_reg[idx_reg];
                pu_angle  = cox_reg;
                pu_neg    = 1'b0;
            end
            2'd1: begin
                pu_center = jc_f_reg[idx_reg];
                pu_angle  = fem_reg;
                pu_neg    = 1'b1;
            end
            default: begin
                pu_center = jc_t_reg[idx_reg];
                pu_angle  = tib_reg;
                pu_neg    = 1'b1;
            end
        endcase
        pu_out = lik_pkg::to_pulse(pu_center, pu_angle, pu_neg);
    end

    // ---------------- sequencer ----------------
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == lik_pkg::OP_WRITE)   state_next = ST_DONE;
                    else if (in_op != lik_pkg::OP_NONE) state_next = ST_SQX;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_R1;
            ST_R1:   state_next = ST_SQRT;
            ST_D:    state_next = ST_SQD;
            ST_SQD:  state_next = ST_SQZ;
            ST_SQZ:  state_next = ST_R2;
            ST_R2:   state_next = ST_SQRT;
            ST_LF2:  state_next = ST_LT2;
            ST_LT2:  state_next = ST_LFR;
            ST_LFR:  state_next = ST_LTLF;
            ST_LTLF: state_next = ST_NUMS;
            ST_NUMS: state_next = ST_COX;
            ST_COX:  state_next = ST_ANORM;
            ST_COXD: state_next = ST_ANORM;
            ST_F1D:  state_next = ST_AC;
            ST_AC:   state_next = (ac_den == '0) ? ST_ACD : ST_ACM;
            ST_ACM:  state_next = ST_ACQ;
            ST_ACQ:  state_next = ST_SQRT;
            ST_ACA:  state_next = ST_ANORM;
            ST_ACD:  state_next = acs_reg ? ST_PUL : ST_AC;
            ST_PUL:  state_next = (pcnt_reg == 2'd2) ? ST_DONE : ST_PUL;
            ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
            ST_SQRT: state_next = (sq_cnt_reg == 5'd31) ? sq_ret_reg : ST_SQRT;
            ST_ANORM: begin
                if (cx_reg == '0 && cy_reg == '0)  state_next = at_ret_reg;
                else if (at_or >= 45'(64'd1 << 40)) state_next = ST_AROT;
            end
            ST_AROT:  state_next = (at_i_reg == 5'(lik_pkg::CORDIC_STEPS - 1)) ? ST_AFIN
                                                                               : ST_AROT;
            ST_AFIN:  state_next = at_ret_reg;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sq_ret_reg <= ST_IDLE;
            at_ret_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_R1:   sq_ret_reg <= ST_D;
                ST_R2:   sq_ret_reg <= ST_LF2;
                ST_ACQ:  sq_ret_reg <= ST_ACA;
                ST_COX:  at_ret_reg <= ST_COXD;
                ST_COXD: at_ret_reg <= ST_F1D;
                ST_ACA:  at_ret_reg <= ST_ACD;
                default: ;
            endcase
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg     <= 13'd1024;
            lf_reg     <= 13'd1536;
            lt_reg     <= 13'd2816;
            corner_reg <= 7'd45;
            back_reg   <= 7'd40;
            fwd_reg    <= 7'd20;
            jlim_reg   <= 7'd90;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lik_pkg::REG_COXA_LEN:  lc_reg     <= cfg_data;
                lik_pkg::REG_FEMUR_LEN: lf_reg     <= cfg_data;
                lik_pkg::REG_TIBIA_LEN: lt_reg     <= cfg_data;
                lik_pkg::REG_CORNER:    corner_reg <= cfg_data[lik_pkg::LIM_W-1:0];
                lik_pkg::REG_MID_BACK:  back_reg   <= cfg_data[lik_pkg::LIM_W-1:0];
                lik_pkg::REG_MID_FWD:   fwd_reg    <= cfg_data[lik_pkg::LIM_W-1:0];
                lik_pkg::REG_JOINT:     jlim_reg   <= cfg_data[lik_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- per-leg store ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEGS; i++) begin
                foot_x_reg[i] <= '0;
                foot_y_reg[i] <= '0;
                foot_z_reg[i] <= '0;
                jc_c_reg[i]   <= lik_pkg::CENTER_RESET;
                jc_f_reg[i]   <= lik_pkg::CENTER_RESET;
                jc_t_reg[i]   <= lik_pkg::CENTER_RESET;
            end
        end else if (accept) begin
            if (in_op == lik_pkg::OP_WRITE) begin
                jc_c_reg[in_idx] <= in_cc;
                jc_f_reg[in_idx] <= in_fc;
                jc_t_reg[in_idx] <= in_tc;
            end else if (in_op != lik_pkg::OP_NONE) begin
                foot_x_reg[in_idx] <= new_x;
                foot_y_reg[in_idx] <= new_y;
                foot_z_reg[in_idx] <= new_z;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    leg_reg  <= in_leg;
                    idx_reg  <= in_idx;
                    time_reg <= in_time;
                    x_reg    <= new_x;
                    y_reg    <= new_y;
                    z_reg    <= new_z;
                    unr_reg  <= 1'b0;
                    pc_reg   <= lik_pkg::clamp_pulse(in_cc);
                    pf_reg   <= lik_pkg::clamp_pulse(in_fc);
                    pt_reg   <= lik_pkg::clamp_pulse(in_tc);
                end
            end
            ST_SQY: sum_reg <= mul_reg[32:0];
            ST_D: begin
                d_reg  <= $signed({1'b0, sq_r_reg[15:0]}) - $signed({4'b0, lc_reg});
                zo_reg <= $signed({4'b0, lt_reg}) - $signed({z_reg[15], z_reg});
            end
            ST_SQZ: sum_reg <= mul_reg[32:0];
            ST_R2:  r2_reg  <= 33'(64'(sum_reg) + mul_reg);
            ST_LF2: r_reg   <= sq_r_reg[15:0];
            ST_LT2: lf2_reg <= mul_reg[25:0];
            ST_LFR: lt2_reg <= mul_reg[25:0];
            ST_LTLF: den1_reg <= {mul_reg[29:0], 1'b0};
            ST_NUMS: begin
                den2_reg <= {mul_reg[29:0], 1'b0};
                num1_reg <= $signed({9'b0, lf2_reg}) + $signed({2'b0, r2_reg})
                          - $signed({9'b0, lt2_reg});
                num2_reg <= $signed({9'b0, lt2_reg}) + $signed({9'b0, lf2_reg})
                          - $signed({2'b0, r2_reg});
            end
            ST_COXD: cox_reg <= lik_pkg::clamp_ang(cox_raw, cox_lo, cox_hi);
            ST_F1D: begin
                f1_reg  <= at_res_reg;
                acs_reg <= 1'b0;
            end
            ST_AC: begin
                if (ac_den == '0) begin
                    unr_reg <= 1'b1;
                end else begin
                    if (ac_sat) unr_reg <= 1'b1;
                    nc_reg <= ac_clip;
                    p_reg  <= ac_den - ac_an;
                    q_reg  <= {1'b0, ac_den} + {1'b0, ac_an};
                end
            end
            ST_ACD: begin
                if (acs_reg) begin
                    tib_reg <= lik_pkg::clamp_ang(tib_raw, -jl_ang, jl_ang);
                end else begin
                    fem_reg <= lik_pkg::clamp_ang(fem_raw, -jl_ang, jl_ang);
                end
                acs_reg  <= 1'b1;
                pcnt_reg <= 2'd0;
            end
            ST_PUL: begin
                case (pcnt_reg)
                    2'd0:    pc_reg <= pu_out;
                    2'd1:    pf_reg <= pu_out;
                    default: pt_reg <= pu_out;
                endcase
                pcnt_reg <= pcnt_reg + 2'd1;
            end
            default: ;
        endcase

        // zero denominator gives a zero angle
        if (state_reg == ST_AC && ac_den == '0) at_res_reg <= '0;

        // square root: one result bit a step
        if (sq_go) begin
            sq_v_reg   <= sq_in;
            sq_r_reg   <= '0;
            sq_b_reg   <= 64'd1 << 62;
            sq_cnt_reg <= '0;
        end else if (state_reg == ST_SQRT) begin
            if (sq_v_reg >= sq_rb) begin
                sq_v_reg <= sq_v_reg - sq_rb;
                sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_b_reg   <= sq_b_reg >> 2;
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
        end

        // atan2: normalize, rotate, then mirror into the input quadrant
        if (at_go) begin
            cx_reg      <= $signed(45'(at_ax));
            cy_reg      <= $signed(45'(at_ay));
            at_xneg_reg <= at_x_in[lik_pkg::ATIN_W-1];
            at_yneg_reg <= at_y_in[lik_pkg::ATIN_W-1];
            at_i_reg    <= '0;
            z_reg_a     <= '0;
        end else if (state_reg == ST_ANORM) begin
            if (cx_reg == '0 && cy_reg == '0) begin
                at_res_reg <= '0;
            end else if (at_or < 45'(64'd1 << 36)) begin
                cx_reg <= cx_reg <<< 4;
                cy_reg <= cy_reg <<< 4;
            end else if (at_or < 45'(64'd1 << 40)) begin
                cx_reg <= cx_reg <<< 1;
                cy_reg <= cy_reg <<< 1;
            end
        end else if (state_reg == ST_AROT) begin
            if (!cy_reg[lik_pkg::CORD_W-1]) begin
                cx_reg  <= cx_reg + at_dx;
                cy_reg  <= cy_reg - at_dy;
                z_reg_a <= z_reg_a + lik_pkg::arc_at(at_i_reg);
            end else begin
                cx_reg  <= cx_reg - at_dx;
                cy_reg  <= cy_reg + at_dy;
                z_reg_a <= z_reg_a - lik_pkg::arc_at(at_i_reg);
            end
            at_i_reg <= at_i_reg + 5'd1;
        end else if (state_reg == ST_AFIN) begin
            at_res_reg <= at_yneg_reg ? -at_half : at_half;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_leg_reg  <= leg_reg;
            m_pc_reg   <= pc_reg;
            m_pf_reg   <= pf_reg;
            m_pt_reg   <= pt_reg;
            m_time_reg <= time_reg;
            m_unr_reg  <= unr_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_time_reg, m_pt_reg, m_pf_reg, m_pc_reg, m_leg_reg};
    assign m_tuser  = m_unr_reg;

endmodule

`default_nettype wire
